// ===== rtl/core/b64sd_pkg.sv =====
// shared types, constants and character decode functions of the base64 stream decoder
package b64sd_pkg;

    // widths and limits
    localparam int CFG_W      = 13;
    localparam int COUNT_W    = 13;
    localparam int LIMIT_MAX  = 4096;
    localparam int MAX_RESET  = 256;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_NUL_CODE = 8'h00;
    localparam logic [7:0] CH_PAD      = 8'h3D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0  = 8'h30;
    localparam logic [7:0] CH_DIGIT_9  = 8'h39;

    // result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        CLS_NUL,
        CLS_SKIP,
        CLS_ALPHA,
        CLS_BAD
    } t_char_class;

    typedef struct packed {
        logic [5:0]         leftover_bits;
        logic [2:0]         leftover_count;
        logic [COUNT_W-1:0] emitted_count;
        logic               error_seen;
        logic               stopped;
    } t_chunk_state;

    typedef struct packed {
        logic               kind;
        logic [7:0]         data_byte;
        logic [COUNT_W-1:0] byte_count;
        logic               bad_char;
        logic               run_last;
    } t_result;

    // class of one input character
    function automatic t_char_class char_class(input logic [7:0] ch);
        t_char_class cls;
        if (ch == CH_NUL_CODE) begin
            cls = CLS_NUL;
        end else if (ch inside {CH_PAD, CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
            cls = CLS_SKIP;
        end else if (ch inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z],
                                [CH_DIGIT_0:CH_DIGIT_9], CH_PLUS, CH_SLASH}) begin
            cls = CLS_ALPHA;
        end else begin
            cls = CLS_BAD;
        end
        return cls;
    endfunction

    // 6-bit value of an alphabet character
    function automatic logic [5:0] sextet_of(input logic [7:0] ch);
        logic [7:0] diff;
        diff = 8'h00;
        if (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            diff = ch - CH_UPPER_A;
        end else if (ch inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            diff = ch - CH_LOWER_A + 8'd26;
        end else if (ch inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            diff = ch - CH_DIGIT_0 + 8'd52;
        end else if (ch == CH_PLUS) begin
            diff = 8'd62;
        end else if (ch == CH_SLASH) begin
            diff = 8'd63;
        end
        return diff[5:0];
    endfunction

endpackage

// ===== rtl/core/base64_stream_decoder.sv =====
// top level of the base64 stream decoder: input register, chunk state and result queue
// The decoder takes one base64 character request per clock while the result queue has room,
// and returns decoded bytes and one end-of-chunk summary per chunk. A request is registered
// in the input register, decoded from there and its results (none, one or two) are written to
// a four-entry result queue once the queue has room; the first result then shows on o_valid.
// Input is taken every cycle as long as the queue holds at most two results; the sustained
// rate is one request per clock while i_ready is high and each request yields at most one
// result, and one result per clock on the output side, so a chunk whose items each yield two
// results runs at the output rate. The byte limit i_cfg_data is written through its own
// channel, which is always ready, and must be written only while the decoder is idle.
module base64_stream_decoder (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [b64sd_pkg::CFG_W-1:0]           i_cfg_data,
    // character requests
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_has_char,
    input  logic [7:0]                            i_char_code,
    input  logic                                  i_chunk_end,
    // results
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_kind,
    output logic [7:0]                            o_data_byte,
    output logic [b64sd_pkg::COUNT_W-1:0]         o_byte_count,
    output logic                                  o_bad_char,
    output logic                                  o_run_last
);

    logic [b64sd_pkg::CFG_W-1:0]     r_max_out_bytes;
    logic                            r_in_valid;
    logic                            r_has_char;
    logic [7:0]                      r_char_code;
    logic                            r_chunk_end;
    b64sd_pkg::t_chunk_state         r_state;
    b64sd_pkg::t_chunk_state         n_state;
    b64sd_pkg::t_result              res0;
    b64sd_pkg::t_result              res1;
    b64sd_pkg::t_result              out_res;
    logic [1:0]                      step_push;
    logic [1:0]                      push_cnt;
    logic [b64sd_pkg::FIFO_CW-1:0]   q_count;
    logic                            advance;
    logic                            in_take;
    logic [b64sd_pkg::COUNT_W-1:0]   limit;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_out_bytes <= b64sd_pkg::CFG_W'(b64sd_pkg::MAX_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_out_bytes <= i_cfg_data;
        end
    end

    // effective byte limit
    assign limit = (r_max_out_bytes > b64sd_pkg::CFG_W'(b64sd_pkg::LIMIT_MAX))
                 ? b64sd_pkg::COUNT_W'(b64sd_pkg::LIMIT_MAX)
                 : b64sd_pkg::COUNT_W'(r_max_out_bytes);

    // handshake on the input side
    assign advance = r_in_valid && (q_count <= b64sd_pkg::FIFO_CW'(b64sd_pkg::FIFO_DEPTH - 2));
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_has_char  <= i_has_char;
            r_char_code <= i_char_code;
            r_chunk_end <= i_chunk_end;
        end
    end

    // decode step
    b64sd_step u_step (
        .i_state     (r_state),
        .i_limit     (limit),
        .i_has_char  (r_has_char),
        .i_char_code (r_char_code),
        .i_chunk_end (r_chunk_end),
        .o_state     (n_state),
        .o_res0      (res0),
        .o_res1      (res1),
        .o_push_cnt  (step_push)
    );

    // chunk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    assign push_cnt = advance ? step_push : 2'd0;

    // result queue
    b64sd_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_wr0      (res0),
        .i_wr1      (res1),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (out_res),
        .o_count    (q_count)
    );

    assign o_kind       = out_res.kind;
    assign o_data_byte  = out_res.data_byte;
    assign o_byte_count = out_res.byte_count;
    assign o_bad_char   = out_res.bad_char;
    assign o_run_last   = out_res.run_last;

    // emitted byte count never passes the limit ceiling
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.emitted_count <= b64sd_pkg::COUNT_W'(b64sd_pkg::LIMIT_MAX))
        else $error("emitted count beyond limit");

    // a double push is always a data byte followed by the summary
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_cnt == 2'd2) |->
        (res0.kind == b64sd_pkg::KIND_DATA && res1.kind == b64sd_pkg::KIND_END))
        else $error("bad result ordering");

    // chunk state is cleared after a chunk end request is decoded
    a_chunk_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_chunk_end) |=> (r_state == '0))
        else $error("chunk state not cleared");

endmodule

// ===== rtl/core/b64sd_step.sv =====
// one decode step: next chunk state and up to two results for one character request
module b64sd_step (
    input  b64sd_pkg::t_chunk_state                i_state,
    input  logic [b64sd_pkg::COUNT_W-1:0]          i_limit,
    input  logic                                   i_has_char,
    input  logic [7:0]                             i_char_code,
    input  logic                                   i_chunk_end,
    output b64sd_pkg::t_chunk_state                o_state,
    output b64sd_pkg::t_result                     o_res0,
    output b64sd_pkg::t_result                     o_res1,
    output logic [1:0]                             o_push_cnt
);

    b64sd_pkg::t_char_class       cls;
    logic [5:0]                   sextet;
    logic [11:0]                  acc;
    logic [3:0]                   cnt;
    logic [3:0]                   cnt_left;
    logic                         active;
    logic                         byte_ready;
    logic                         emit;
    logic [7:0]                   byte_val;
    logic [11:0]                  left_mask;
    logic [b64sd_pkg::COUNT_W-1:0] emitted_next;
    b64sd_pkg::t_chunk_state      st;
    b64sd_pkg::t_result           data_res;
    b64sd_pkg::t_result           end_res;

    // character decode and accumulator
    always_comb begin
        cls          = b64sd_pkg::char_class(i_char_code);
        sextet       = b64sd_pkg::sextet_of(i_char_code);
        active       = i_has_char && !i_state.stopped && !i_state.error_seen;
        acc          = {i_state.leftover_bits, sextet};
        cnt          = {1'b0, i_state.leftover_count} + 4'd6;
        byte_ready   = (cnt >= 4'd8);
        cnt_left     = byte_ready ? (cnt - 4'd8) : cnt;
        byte_val     = 8'(acc >> cnt_left);
        left_mask    = (12'd1 << cnt_left) - 12'd1;
        emit         = active && (cls == b64sd_pkg::CLS_ALPHA) && byte_ready
                       && (i_state.emitted_count < i_limit);
        emitted_next = i_state.emitted_count + b64sd_pkg::COUNT_W'(1);
    end

    // state after the character
    always_comb begin
        st = i_state;
        if (active) begin
            case (cls)
                b64sd_pkg::CLS_NUL: begin
                    st.stopped = 1'b1;
                end
                b64sd_pkg::CLS_SKIP: begin
                    st = i_state;
                end
                b64sd_pkg::CLS_ALPHA: begin
                    st.leftover_bits  = 6'(acc & left_mask);
                    st.leftover_count = cnt_left[2:0];
                    if (emit) begin
                        st.emitted_count = emitted_next;
                    end
                end
                default: begin
                    st.error_seen = 1'b1;
                end
            endcase
        end
    end

    // result records
    always_comb begin
        data_res.kind       = b64sd_pkg::KIND_DATA;
        data_res.data_byte  = byte_val;
        data_res.byte_count = emitted_next;
        data_res.bad_char   = 1'b0;
        data_res.run_last   = !i_chunk_end;

        end_res.kind        = b64sd_pkg::KIND_END;
        end_res.data_byte   = 8'h00;
        end_res.byte_count  = st.emitted_count;
        end_res.bad_char    = st.error_seen;
        end_res.run_last    = 1'b1;
    end

    // ordering and chunk clear
    always_comb begin
        o_res0     = emit ? data_res : end_res;
        o_res1     = end_res;
        o_push_cnt = 2'({1'b0, emit} + {1'b0, i_chunk_end});
        o_state    = i_chunk_end ? '0 : st;
    end

endmodule

// ===== rtl/core/b64sd_out_fifo.sv =====
// result queue: takes up to two results a cycle, delivers one when i_ready is high
module b64sd_out_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [1:0]                        i_push_cnt,
    input  b64sd_pkg::t_result                i_wr0,
    input  b64sd_pkg::t_result                i_wr1,
    output logic                              o_valid,
    input  logic                              i_ready,
    output b64sd_pkg::t_result                o_data,
    output logic [b64sd_pkg::FIFO_CW-1:0]     o_count
);

    b64sd_pkg::t_result                r_mem [b64sd_pkg::FIFO_DEPTH];
    logic [b64sd_pkg::FIFO_AW-1:0]     r_head;
    logic [b64sd_pkg::FIFO_AW-1:0]     r_tail;
    logic [b64sd_pkg::FIFO_CW-1:0]     r_count;
    logic [b64sd_pkg::FIFO_AW-1:0]     n_head;
    logic [b64sd_pkg::FIFO_AW-1:0]     n_tail;
    logic [b64sd_pkg::FIFO_CW-1:0]     n_count;
    logic                              pop;
    logic [b64sd_pkg::FIFO_AW-1:0]     tail_plus1;

    // pointer arithmetic
    always_comb begin
        pop        = (r_count != '0) && i_ready;
        tail_plus1 = r_tail + b64sd_pkg::FIFO_AW'(1);
        n_head     = r_head + b64sd_pkg::FIFO_AW'(pop);
        n_tail     = r_tail + b64sd_pkg::FIFO_AW'(i_push_cnt);
        n_count    = r_count + b64sd_pkg::FIFO_CW'(i_push_cnt) - b64sd_pkg::FIFO_CW'(pop);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_tail] <= i_wr0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[tail_plus1] <= i_wr1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];
    assign o_count = r_count;

    // no overflow of the queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= b64sd_pkg::FIFO_CW'(b64sd_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // a push never arrives when there is no room for it
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |->
        (r_count <= b64sd_pkg::FIFO_CW'(b64sd_pkg::FIFO_DEPTH - 2)))
        else $error("push into full result queue");

endmodule

// ===== verif/tb_base64_stream_decoder.sv =====
// self-checking testbench of the base64 stream decoder: directed rows, random chunks, limit sweep
`timescale 1ns / 1ps

module tb_base64_stream_decoder;
    import b64sd_pkg::*;

    // sextet ranks of the alphabet groups
    localparam int LOWER_RANK_BASE = 26;
    localparam int DIGIT_RANK_BASE = 52;
    localparam int PLUS_RANK       = 62;
    localparam int SLASH_RANK      = 63;
    localparam int SETTLE_CYCLES   = 8;
    localparam int SCRIPT_LEN      = 26;

    // one directed row; count and bad only matter where typed is set
    typedef struct packed {
        logic               has;
        logic [7:0]         code;
        logic               last;
        logic               typed;
        logic [COUNT_W-1:0] count;
        logic               bad;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic               i_has_char;
    logic [7:0]         i_char_code;
    logic               i_chunk_end;
    logic               o_valid;
    logic               i_ready;
    logic               o_kind;
    logic [7:0]         o_data_byte;
    logic [COUNT_W-1:0] o_byte_count;
    logic               o_bad_char;
    logic               o_run_last;

    // decoder state as the testbench sees it
    logic [5:0]         held_bits;
    logic [2:0]         held_count;
    logic [COUNT_W-1:0] bytes_out;
    logic               saw_bad;
    logic               halted;
    logic [CFG_W-1:0]   byte_limit;

    t_result expected_decode[$];
    t_row    script [SCRIPT_LEN];

    // request currently driven carries a typed-in expectation
    logic    fixed_expect;
    t_result fixed_result;

    int gap_odds;
    int stall_odds;
    int stall_left;
    int stim_count;
    int chunk_count;
    int mismatch_count;
    int results_checked;
    int bytes_seen;
    int ends_seen;

    base64_stream_decoder DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_has_char   (i_has_char),
        .i_char_code  (i_char_code),
        .i_chunk_end  (i_chunk_end),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_data_byte  (o_data_byte),
        .o_byte_count (o_byte_count),
        .o_bad_char   (o_bad_char),
        .o_run_last   (o_run_last)
    );

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    // hard stop if the run hangs
    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    // rank of an alphabet character, -1 for anything else
    function automatic int alphabet_rank(input logic [7:0] ch);
        int rank;
        rank = -1;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            rank = int'(ch - CH_UPPER_A);
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            rank = int'(ch - CH_LOWER_A) + LOWER_RANK_BASE;
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            rank = int'(ch - CH_DIGIT_0) + DIGIT_RANK_BASE;
        end else if (ch == CH_PLUS) begin
            rank = PLUS_RANK;
        end else if (ch == CH_SLASH) begin
            rank = SLASH_RANK;
        end
        return rank;
    endfunction

    function automatic logic is_filler(input logic [7:0] ch);
        return ch inside {CH_PAD, CH_SPACE, CH_TAB, CH_CR, CH_LF};
    endfunction

    // character for a given rank
    function automatic logic [7:0] rank_to_char(input int rank);
        logic [7:0] ch;
        if (rank < LOWER_RANK_BASE) begin
            ch = CH_UPPER_A + 8'(rank);
        end else if (rank < DIGIT_RANK_BASE) begin
            ch = CH_LOWER_A + 8'(rank - LOWER_RANK_BASE);
        end else if (rank < PLUS_RANK) begin
            ch = CH_DIGIT_0 + 8'(rank - DIGIT_RANK_BASE);
        end else if (rank == PLUS_RANK) begin
            ch = CH_PLUS;
        end else begin
            ch = CH_SLASH;
        end
        return ch;
    endfunction

    function automatic logic [7:0] pick_filler();
        logic [7:0] ch;
        case ($urandom_range(0, 4))
            0: ch = CH_PAD;
            1: ch = CH_SPACE;
            2: ch = CH_TAB;
            3: ch = CH_CR;
            default: ch = CH_LF;
        endcase
        return ch;
    endfunction

    // any nonzero byte outside the alphabet and the skipped set
    function automatic logic [7:0] pick_bad();
        logic [7:0] ch;
        do begin
            ch = 8'($urandom_range(1, 255));
        end while (alphabet_rank(ch) >= 0 || is_filler(ch));
        return ch;
    endfunction

    function automatic int pick_odds();
        int odds;
        case ($urandom_range(0, 3))
            0: odds = 0;
            1: odds = 3;
            2: odds = 8;
            default: odds = 24;
        endcase
        return odds;
    endfunction

    function automatic void clear_chunk_state();
        held_bits  = '0;
        held_count = '0;
        bytes_out  = '0;
        saw_bad    = 1'b0;
        halted     = 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      results_checked, name, got, want));
        end
    endtask

    // decode one accepted request and queue the results it should give
    task automatic decode_request(input logic has, input logic [7:0] ch, input logic last,
                                  input logic typed, input t_result typed_result);
        t_result     batch[$];
        t_result     res;
        int          rank;
        int          cap;
        logic [11:0] acc;
        logic [3:0]  cnt;
        if (has && !halted && !saw_bad) begin
            if (ch == CH_NUL_CODE) begin
                halted = 1'b1;
            end else if (!is_filler(ch)) begin
                rank = alphabet_rank(ch);
                if (rank < 0) begin
                    saw_bad = 1'b1;
                end else begin
                    acc = {held_bits, 6'(rank)};
                    cnt = {1'b0, held_count} + 4'd6;
                    cap = (int'(byte_limit) > LIMIT_MAX) ? LIMIT_MAX : int'(byte_limit);
                    if (cnt >= 4'd8) begin
                        cnt = cnt - 4'd8;
                        // past the limit the bits are used up silently
                        if (int'(bytes_out) < cap) begin
                            bytes_out = bytes_out + 1'b1;
                            res = '{kind: KIND_DATA, data_byte: 8'(acc >> cnt),
                                    byte_count: bytes_out, bad_char: 1'b0, run_last: 1'b0};
                            batch.push_back(res);
                        end
                    end
                    held_bits  = 6'(acc & ((12'd1 << cnt) - 12'd1));
                    held_count = cnt[2:0];
                end
            end
        end
        if (last) begin
            res = '{kind: KIND_END, data_byte: 8'h00, byte_count: bytes_out,
                    bad_char: saw_bad, run_last: 1'b0};
            batch.push_back(res);
            clear_chunk_state();
        end
        if (batch.size() > 0) begin
            batch[batch.size() - 1].run_last = 1'b1;
        end
        if (typed) begin
            expected_decode.push_back(typed_result);
        end else begin
            foreach (batch[k]) begin
                expected_decode.push_back(batch[k]);
            end
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_decode.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d byte %02h count %0d",
                                      o_kind, o_data_byte, o_byte_count));
        end else begin
            want = expected_decode.pop_front();
            check_field("kind", o_kind, want.kind);
            check_field("data_byte", o_data_byte, want.data_byte);
            check_field("byte_count", o_byte_count, want.byte_count);
            check_field("bad_char", o_bad_char, want.bad_char);
            check_field("run_last", o_run_last, want.run_last);
            if (want.kind == KIND_END) begin
                ends_seen++;
            end else begin
                bytes_seen++;
            end
        end
        results_checked++;
    endtask

    // monitor: register writes, accepted requests and results, all sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                byte_limit = i_cfg_data;
            end
            if (i_valid && o_ready) begin
                decode_request(i_has_char, i_char_code, i_chunk_end, fixed_expect,
                               fixed_result);
            end
            if (o_valid && i_ready) begin
                check_result();
            end
        end
    end

    // result side: ready with random stall bursts
    initial begin
        i_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
                stall_left = $urandom_range(0, 12);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // drive one request and hold it until taken
    task automatic send_request(input logic has, input logic [7:0] ch, input logic last,
                                input logic typed, input t_result want);
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_has_char   <= has;
        i_char_code  <= ch;
        i_chunk_end  <= last;
        fixed_expect <= typed;
        fixed_result <= want;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic paced_send(input logic has, input logic [7:0] ch, input logic last);
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            idle_cycles($urandom_range(1, 13));
        end
        send_request(has, ch, last, 1'b0, '0);
    endtask

    // stop sending until every result is back, then let requests without results drain
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_decode.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one chunk of random text, mostly clean, sometimes cut by a bad or NUL character
    task automatic random_chunk(input int longest);
        int         len;
        int         fault_kind;
        int         fault_at;
        logic       tail;
        logic [7:0] ch;
        len        = ($urandom_range(0, 9) == 0) ? $urandom_range(1, longest)
                                                 : $urandom_range(1, 12);
        fault_kind = $urandom_range(0, 9);
        fault_at   = $urandom_range(0, len - 1);
        tail       = 1'($urandom_range(0, 1));
        for (int k = 0; k < len; k++) begin
            // idle request that carries neither a character nor an end
            if ($urandom_range(0, 11) == 0) begin
                paced_send(1'b0, 8'($urandom), 1'b0);
            end
            if (k == fault_at && fault_kind < 2) begin
                ch = pick_bad();
            end else if (k == fault_at && fault_kind == 2) begin
                ch = CH_NUL_CODE;
            end else if ($urandom_range(0, 9) == 0) begin
                ch = pick_filler();
            end else begin
                ch = rank_to_char($urandom_range(0, SLASH_RANK));
            end
            paced_send(1'b1, ch, tail && (k == len - 1));
            stim_count++;
        end
        // end on its own request, now and then with an arbitrary character on it
        if (!tail) begin
            paced_send(1'($urandom_range(0, 3) == 0), 8'($urandom), 1'b1);
            stim_count++;
        end
        chunk_count++;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] limit, input int items, input bit calm);
        int target;
        settle();
        write_limit(limit);
        gap_odds   = calm ? 0 : pick_odds();
        stall_odds = calm ? 0 : pick_odds();
        target = stim_count + items;
        while (stim_count < target) begin
            random_chunk(60);
            if (!calm && $urandom_range(0, 39) == 0) begin
                settle();
            end
        end
    endtask

    // stimulus
    initial begin
        t_result want;
        int      waited;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_has_char   = 1'b0;
        i_char_code  = 8'h00;
        i_chunk_end  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        fixed_expect = 1'b0;
        fixed_result = '0;
        gap_odds     = 0;
        stall_odds   = 0;
        stim_count   = 0;
        chunk_count  = 0;
        mismatch_count  = 0;
        results_checked = 0;
        bytes_seen   = 0;
        ends_seen    = 0;
        clear_chunk_state();
        byte_limit   = CFG_W'(MAX_RESET);

        // directed rows: has, code, last, typed, count, bad
        script = '{
            // empty chunk straight out of reset
            '{1'b0, 8'h00,       1'b1, 1'b1, 13'd0, 1'b0},
            // alphabet extremes with every skipped character in between
            '{1'b1, "A",         1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, "/",         1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, CH_PAD,      1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, "+",         1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, CH_SPACE,    1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, "z",         1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, CH_TAB,      1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, CH_CR,       1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, CH_LF,       1'b0, 1'b0, 13'd0, 1'b0},
            // no character, no end: nothing comes out
            '{1'b0, 8'hFF,       1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b0, 8'h00,       1'b1, 1'b1, 13'd3, 1'b0},
            // NUL stops the chunk without an error
            '{1'b1, "Z",         1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, "a",         1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, CH_NUL_CODE, 1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, "B",         1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b0, 8'h00,       1'b1, 1'b1, 13'd1, 1'b0},
            // bad character after one byte, rest ignored
            '{1'b1, "0",         1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, "9",         1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, 8'hFF,       1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, "Q",         1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b0, 8'h00,       1'b1, 1'b1, 13'd1, 1'b1},
            // bad character on the end request itself
            '{1'b1, 8'h80,       1'b1, 1'b1, 13'd0, 1'b1},
            // character and end together: byte then summary
            '{1'b1, "M",         1'b0, 1'b0, 13'd0, 1'b0},
            '{1'b1, "W",         1'b1, 1'b0, 13'd0, 1'b0},
            // NUL on the end request
            '{1'b1, CH_NUL_CODE, 1'b1, 1'b1, 13'd0, 1'b0}
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        gap_odds   = 4;
        stall_odds = 4;
        foreach (script[k]) begin
            want = '{kind: KIND_END, data_byte: 8'h00, byte_count: script[k].count,
                     bad_char: script[k].bad, run_last: 1'b1};
            if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
                idle_cycles($urandom_range(1, 13));
            end
            send_request(script[k].has, script[k].code, script[k].last, script[k].typed, want);
        end

        // limit sweep; the last phase runs without idling on either side
        run_phase(CFG_W'(0), 200, 1'b0);
        run_phase(CFG_W'(1), 250, 1'b0);
        run_phase(CFG_W'(3), 250, 1'b0);
        run_phase(CFG_W'(8191), 150, 1'b0);
        run_phase(CFG_W'($urandom_range(4, 60)), 300, 1'b0);
        run_phase(CFG_W'(LIMIT_MAX), 300, 1'b0);
        run_phase(CFG_W'(2), 200, 1'b0);
        run_phase(CFG_W'($urandom_range(0, 8191)), 350, 1'b1);

        @(negedge i_clk);
        i_valid <= 1'b0;
        waited = 0;
        while (expected_decode.size() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (expected_decode.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_decode.size()));
        end

        $display("summary: %0d requests in %0d chunks, %0d bytes and %0d chunk ends checked",
                 stim_count, chunk_count, bytes_seen, ends_seen);
        $display("summary: byte limits from 0 to 8191, bad and NUL characters mid-chunk");
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
